// ----- design/firlp_pkg.sv -----
`timescale 1ns / 1ps

package firlp_pkg;

	// coefficient format: signed, FRAC_BITS fraction bits, output gain folded in
	localparam int COEF_BITS  = 16;
	localparam int FRAC_BITS  = 16;
	localparam int COEF_COUNT = 17;
	localparam int LEVEL_BITS = 8;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'd255;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	// symmetric low-pass taps, zero past the end of the table
	function automatic coef_t coef(input int idx);
		coef_t c;
		case (idx)
			0, 16:   c = -16'sd558;
			1, 15:   c = -16'sd1369;
			2, 14:   c = -16'sd1636;
			3, 13:   c = -16'sd1010;
			4, 12:   c = 16'sd572;
			5, 11:   c = 16'sd2821;
			6, 10:   c = 16'sd5162;
			7, 9:    c = 16'sd6927;
			8:       c = 16'sd7582;
			default: c = '0;
		endcase
		return c;
	endfunction

	// node count at a given level of the 4-way adder tree
	function automatic int tree_nodes(input int taps, input int level);
		int n;
		n = taps;
		for (int l = 0; l < level; l++) begin
			n = (n + 3) >> 2;
		end
		return n;
	endfunction

	// number of registered levels until one node remains
	function automatic int tree_levels(input int taps);
		int n;
		int l;
		n = taps;
		l = 0;
		while (n > 1) begin
			n = (n + 3) >> 2;
			l++;
		end
		return l;
	endfunction

endpackage

// ----- design/firlp_tap_cell.sv -----
`timescale 1ns / 1ps

module firlp_tap_cell #(
	parameter int SAMPLE_BITS = 9,
	parameter firlp_pkg::coef_t COEF = '0,
	parameter bit HOLD = 1'b1
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            shift_en,
	input  logic                                            load_en,
	input  logic [SAMPLE_BITS-1:0]                          x_in,
	output logic [SAMPLE_BITS-1:0]                          x_out,
	output logic signed [SAMPLE_BITS+firlp_pkg::COEF_BITS:0] prod
);

	localparam int PROD_BITS = SAMPLE_BITS + firlp_pkg::COEF_BITS + 1;

	logic signed [PROD_BITS-1:0] prod_s1;

	// delay line element when HOLD is set, passes its sample on to the next cell; else x_out is zero
	generate
		if (HOLD) begin : g_hold
			logic [SAMPLE_BITS-1:0] x_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					x_q <= '0;
				end else if (shift_en) begin
					x_q <= x_in;
				end
			end
			assign x_out = x_q;
		end else begin : g_end
			assign x_out = '0;
		end
	endgenerate

	// tap product, registered
	always_ff @(posedge clk) begin
		if (load_en) begin
			prod_s1 <= PROD_BITS'($signed({1'b0, x_in}) * COEF);
		end
	end

	assign prod = prod_s1;

endmodule

// ----- design/firlp_add_tree.sv -----
`timescale 1ns / 1ps

module firlp_add_tree #(
	parameter int TAPS = 17,
	parameter int SUM_BITS = 31
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SUM_BITS-1:0] in_terms [TAPS],
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SUM_BITS-1:0] out_sum
);

	localparam int LEVELS = firlp_pkg::tree_levels(TAPS);

	logic signed [SUM_BITS-1:0] node_q [1:LEVELS][TAPS];
	logic [LEVELS:1]            valid_q;
	logic [LEVELS+1:1]          ready;

	// a level loads when it is empty or the level below moves on
	always_comb begin
		ready[LEVELS+1] = out_ready;
		for (int l = LEVELS; l >= 1; l--) begin
			ready[l] = !valid_q[l] || ready[l+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ready[1]) begin
				valid_q[1] <= in_valid;
			end
			for (int l = 2; l <= LEVELS; l++) begin
				if (ready[l]) begin
					valid_q[l] <= valid_q[l-1];
				end
			end
		end
	end

	// 4-input adders, one register level each
	generate
		for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
			localparam int CNT  = firlp_pkg::tree_nodes(TAPS, l);
			localparam int PREV = firlp_pkg::tree_nodes(TAPS, l - 1);
			for (genvar i = 0; i < CNT; i++) begin : g_node
				logic signed [SUM_BITS-1:0] term [4];
				for (genvar j = 0; j < 4; j++) begin : g_term
					if (4 * i + j < PREV) begin : g_use
						if (l == 1) begin : g_in
							assign term[j] = in_terms[4*i+j];
						end else begin : g_up
							assign term[j] = node_q[l-1][4*i+j];
						end
					end else begin : g_zero
						assign term[j] = '0;
					end
				end
				always_ff @(posedge clk) begin
					if (ready[l]) begin
						node_q[l][i] <= term[0] + term[1] + term[2] + term[3];
					end
				end
			end
		end
	endgenerate

	assign in_ready  = ready[1];
	assign out_valid = valid_q[LEVELS];
	assign out_sum   = node_q[LEVELS][0];

endmodule

// ----- design/fir_lowpass_17tap_clamped.sv -----
`timescale 1ns / 1ps
// Path: an accepted sample passes the product register, the L levels of the 4-way
// adder tree (ceil(log4(TAPS)); L = 3 at 17 taps) and the output register (m_tvalid).
// Throughput: one sample per cycle, set by the fully pipelined tap cells and adder tree;
// stalls on the output back up one stage at a time, so empty stages still take data.
// Reset: arst_n clears the delay line and all valid flags; product and sum registers
// are not reset.

module fir_lowpass_17tap_clamped #(
	parameter int TAPS = 17,
	parameter int SAMPLE_BITS = 9
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // [SAMPLE_BITS-1:0] sample
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [firlp_pkg::LEVEL_BITS-1:0]       m_tdata   // [7:0] level
);

	localparam int PROD_BITS = SAMPLE_BITS + firlp_pkg::COEF_BITS + 1;
	localparam int SUM_BITS  = PROD_BITS + $clog2(TAPS);
	localparam int FB        = firlp_pkg::FRAC_BITS;
	localparam int LB        = firlp_pkg::LEVEL_BITS;

	logic [SAMPLE_BITS-1:0]      x [TAPS];
	logic signed [PROD_BITS-1:0] prod [TAPS];
	logic signed [SUM_BITS-1:0]  terms [TAPS];
	logic                        accept;
	logic                        prod_v_s1;
	logic                        prod_ready;
	logic                        tree_in_ready;
	logic                        tree_out_valid;
	logic                        tree_out_ready;
	logic signed [SUM_BITS-1:0]  tree_sum;
	logic [LB-1:0]               level_c;
	logic [LB-1:0]               level_q;
	logic                        out_v_q;

	assign accept = s_tvalid && s_tready;
	assign x[0]   = s_tdata[SAMPLE_BITS-1:0];

	// product stage handshake
	assign prod_ready = !prod_v_s1 || tree_in_ready;
	assign s_tready   = prod_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s1 <= 1'b0;
		end else if (prod_ready) begin
			prod_v_s1 <= s_tvalid;
		end
	end

	// row of tap cells: delay line plus one constant multiplier each
	generate
		for (genvar k = 0; k < TAPS; k++) begin : g_tap
			if (k < TAPS - 1) begin : g_mid
				firlp_tap_cell #(
					.SAMPLE_BITS(SAMPLE_BITS),
					.COEF(firlp_pkg::coef(k)),
					.HOLD(1'b1)
				) u_cell (
					.clk(clk),
					.arst_n(arst_n),
					.shift_en(accept),
					.load_en(prod_ready),
					.x_in(x[k]),
					.x_out(x[k+1]),
					.prod(prod[k])
				);
			end else begin : g_last
				firlp_tap_cell #(
					.SAMPLE_BITS(SAMPLE_BITS),
					.COEF(firlp_pkg::coef(k)),
					.HOLD(1'b0)
				) u_cell (
					.clk(clk),
					.arst_n(arst_n),
					.shift_en(accept),
					.load_en(prod_ready),
					.x_in(x[k]),
					.x_out(),
					.prod(prod[k])
				);
			end
			assign terms[k] = SUM_BITS'(prod[k]);
		end
	endgenerate

	firlp_add_tree #(
		.TAPS(TAPS),
		.SUM_BITS(SUM_BITS)
	) u_tree (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(prod_v_s1),
		.in_ready(tree_in_ready),
		.in_terms(terms),
		.out_valid(tree_out_valid),
		.out_ready(tree_out_ready),
		.out_sum(tree_sum)
	);

	// scale down and saturate to the 8-bit range
	always_comb begin
		if (tree_sum[SUM_BITS-1]) begin
			level_c = '0;
		end else if (|tree_sum[SUM_BITS-2:FB+LB]) begin
			level_c = firlp_pkg::LEVEL_MAX;
		end else begin
			level_c = tree_sum[FB+LB-1:FB];
		end
	end

	// output register
	assign tree_out_ready = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (tree_out_ready) begin
			out_v_q <= tree_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tree_out_ready) begin
			level_q <= level_c;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = level_q;

	// an accepted sample lands in the product stage
	a_prod_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> prod_v_s1)
		else $error("accepted sample did not reach product stage");

	// the newest delay element holds the last accepted sample
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (x[1] == $past(s_tdata[SAMPLE_BITS-1:0])))
		else $error("delay line did not shift in the sample");

	// with the output register empty every stage can take data
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register empty");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int SAMPLE_BITS = 9;
	localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int PAD_BITS    = TDATA_BITS - SAMPLE_BITS;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
	localparam int TAP_COUNT   = 17;
	localparam int RANDOM_SAMPLES = 750;
	localparam int LONG_HOLD_AFTER = 300;  // results seen before the long receiver hold
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;

	typedef enum int {RUN_NOISE, RUN_STEP, RUN_TOGGLE} run_kind_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [TDATA_BITS-1:0]             s_tdata;   // [8:0] sample
	logic                              m_tvalid;
	logic                              m_tready;
	logic [firlp_pkg::LEVEL_BITS-1:0]  m_tdata;   // [7:0] level

	// Filter predictor plus the queue of levels still owed by the block
	class level_scoreboard;
		int coefs[TAP_COUNT];
		int history[TAP_COUNT-1];
		logic [7:0] expected_levels[$];
		int mismatch_count;
		int results_seen;

		function new();
			coefs = '{-558, -1369, -1636, -1010, 572, 2821, 5162, 6927, 7582,
				6927, 5162, 2821, 572, -1010, -1636, -1369, -558};
			foreach (history[k]) history[k] = 0;
			mismatch_count = 0;
			results_seen = 0;
		endfunction

		// accepted sample: run one filter step and queue the clamped level
		function void note_sample(logic [TDATA_BITS-1:0] word);
			int newest;
			longint acc;
			longint scaled;
			logic [7:0] lvl;
			newest = int'(word[SAMPLE_BITS-1:0]);  // padding bits are ignored
			acc = longint'(coefs[0] * newest);
			for (int k = 1; k < TAP_COUNT; k++) begin
				acc += longint'(coefs[k] * history[k-1]);
			end
			for (int k = TAP_COUNT - 2; k > 0; k--) begin
				history[k] = history[k-1];
			end
			history[0] = newest;
			// saturate low on a negative sum, high past 255
			scaled = acc >>> 16;
			if (acc < 0) begin
				lvl = 8'd0;
			end else if (scaled > 255) begin
				lvl = 8'd255;
			end else begin
				lvl = scaled[7:0];
			end
			expected_levels.push_back(lvl);
		endfunction

		function void report(string msg);
			mismatch_count++;
			if (mismatch_count <= 10) $display("%s", msg);
		endfunction

		// accepted output transaction: compare with the oldest expected level
		function void check_level(logic [7:0] got);
			logic [7:0] want;
			if (expected_levels.size() == 0) begin
				report($sformatf("level %0d arrived with no sample pending", got));
			end else begin
				want = expected_levels.pop_front();
				if (got !== want) begin
					report($sformatf("level mismatch at result %0d: expected %0d, got %0d",
						results_seen, want, got));
				end
			end
			results_seen++;
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction
	endclass

	level_scoreboard sb = new();
	logic [TDATA_BITS-1:0] stimulus[$];

	fir_lowpass_17tap_clamped uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// build a tdata word, optionally with garbage in the padding bits
	task automatic queue_sample(input int value, input bit junk);
		logic [PAD_BITS-1:0] pad;
		pad = junk ? PAD_BITS'($urandom) : '0;
		stimulus.push_back({pad, value[SAMPLE_BITS-1:0]});
	endtask

	// drive one transaction and wait for it to be taken
	task automatic send_sample(input logic [TDATA_BITS-1:0] word);
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(word);
	endtask

	// reset, stimulus, drain and verdict
	initial begin
		int burst;
		int gap;
		int run_left;
		int run_level;
		int value;
		run_kind_t run_kind;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;

		// directed: first sample against a cleared line gives a negative sum
		queue_sample(SAMPLE_MAX, 1'b0);
		queue_sample(0, 1'b1);
		queue_sample(0, 1'b0);
		queue_sample(0, 1'b1);
		queue_sample(0, 1'b0);
		// full scale on the positive taps only, zeros on the negative ones: clamps high
		repeat (9) queue_sample(SAMPLE_MAX, 1'b0);
		repeat (4) queue_sample(0, 1'b0);
		queue_sample('h155, 1'b1);
		queue_sample('h0AA, 1'b1);
		queue_sample('h100, 1'b0);
		queue_sample('h001, 1'b1);

		// random: noise, step runs and full-scale toggling
		run_left  = 0;
		run_kind  = RUN_NOISE;
		run_level = 0;
		repeat (RANDOM_SAMPLES) begin
			if (run_left == 0) begin
				run_kind  = run_kind_t'($urandom_range(0, 2));
				run_left  = $urandom_range(1, 24);
				run_level = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
				if ($urandom_range(0, 3) == 0) run_level = $urandom_range(0, SAMPLE_MAX);
			end
			case (run_kind)
				RUN_NOISE:  value = $urandom_range(0, SAMPLE_MAX);
				RUN_STEP:   value = run_level;
				RUN_TOGGLE: value = run_left[0] ? SAMPLE_MAX : 0;
				default:    value = 0;
			endcase
			run_left--;
			queue_sample(value, $urandom_range(0, 3) == 0);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bursts of back-to-back transactions, most separated by a random gap
		while (stimulus.size() > 0) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && stimulus.size() > 0; i++) begin
				send_sample(stimulus.pop_front());
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// receiver: changing ready patterns plus one long hold to back up the pipeline
	initial begin
		int mode_left;
		int hold_left;
		bit held;
		rx_mode_t mode;

		m_tready <= 1'b0;
		mode_left = 0;
		hold_left = 0;
		held = 1'b0;
		mode = RX_OPEN;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) sb.check_level(m_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!held && sb.results_seen >= LONG_HOLD_AFTER) begin
				held = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(5, 60);
				end
				mode_left--;
				case (mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= 1'b1;
				endcase
			end
		end
	end

	// watchdog
	initial begin
		#200000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/firlp_pkg.sv
design/firlp_tap_cell.sv
design/firlp_add_tree.sv
design/fir_lowpass_17tap_clamped.sv
tb/sv/tb.sv
